// File: src/xoo_pkg.sv
// Xoodoo package: state types, round constants and the single-round function.
`timescale 1ns / 1ps
package xoo_pkg;

    localparam int NUM_ROUNDS = 12;
    localparam int TOTAL_RC   = 12;

    typedef logic [31:0]     t_lane;
    typedef t_lane [3:0]     t_plane;
    typedef t_plane [2:0]    t_state;

    localparam t_lane RC_TABLE [TOTAL_RC] = '{
        32'h0000_0058, 32'h0000_0038, 32'h0000_03C0, 32'h0000_00D0,
        32'h0000_0120, 32'h0000_0014, 32'h0000_0060, 32'h0000_002C,
        32'h0000_0380, 32'h0000_00F0, 32'h0000_01A0, 32'h0000_0012
    };

    function automatic t_state xoo_round(input t_state a, input t_lane rc);
        t_plane p;
        t_plane e;
        t_state s;
        t_state w;
        t_state c;
        t_state r;
        t_lane  q;
        // theta
        for (int x = 0; x < 4; x++) begin
            p[x] = a[0][x] ^ a[1][x] ^ a[2][x];
        end
        for (int x = 0; x < 4; x++) begin
            q    = p[(x + 3) & 3];
            e[x] = {q[26:0], q[31:27]} ^ {q[17:0], q[31:18]};
        end
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 4; x++) begin
                s[y][x] = a[y][x] ^ e[x];
            end
        end
        // rho-west and iota
        for (int x = 0; x < 4; x++) begin
            w[0][x] = s[0][x];
            w[1][x] = s[1][(x + 3) & 3];
            w[2][x] = {s[2][x][20:0], s[2][x][31:21]};
        end
        w[0][0] = w[0][0] ^ rc;
        // chi on pre-chi planes
        for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 4; x++) begin
                c[y][x] = w[y][x] ^ (~w[(y + 1) % 3][x] & w[(y + 2) % 3][x]);
            end
        end
        // rho-east
        for (int x = 0; x < 4; x++) begin
            r[0][x] = c[0][x];
            r[1][x] = {c[1][x][30:0], c[1][x][31]};
            q       = c[2][(x + 2) & 3];
            r[2][x] = {q[23:0], q[31:24]};
        end
        return r;
    endfunction

endpackage

// File: src/xoo_in_if.sv
// Input channel interface: valid/ready plus the twelve input lanes.
`timescale 1ns / 1ps
interface xoo_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] p0_lane0;
    logic [31:0] p0_lane1;
    logic [31:0] p0_lane2;
    logic [31:0] p0_lane3;
    logic [31:0] p1_lane0;
    logic [31:0] p1_lane1;
    logic [31:0] p1_lane2;
    logic [31:0] p1_lane3;
    logic [31:0] p2_lane0;
    logic [31:0] p2_lane1;
    logic [31:0] p2_lane2;
    logic [31:0] p2_lane3;

    modport source (
        output valid, p0_lane0, p0_lane1, p0_lane2, p0_lane3,
        p1_lane0, p1_lane1, p1_lane2, p1_lane3,
        p2_lane0, p2_lane1, p2_lane2, p2_lane3,
        input  ready
    );
    modport sink (
        input  valid, p0_lane0, p0_lane1, p0_lane2, p0_lane3,
        p1_lane0, p1_lane1, p1_lane2, p1_lane3,
        p2_lane0, p2_lane1, p2_lane2, p2_lane3,
        output ready
    );
endinterface

// File: src/xoo_out_if.sv
// Output channel interface: valid/ready plus the twelve result lanes.
`timescale 1ns / 1ps
interface xoo_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] q0_lane0;
    logic [31:0] q0_lane1;
    logic [31:0] q0_lane2;
    logic [31:0] q0_lane3;
    logic [31:0] q1_lane0;
    logic [31:0] q1_lane1;
    logic [31:0] q1_lane2;
    logic [31:0] q1_lane3;
    logic [31:0] q2_lane0;
    logic [31:0] q2_lane1;
    logic [31:0] q2_lane2;
    logic [31:0] q2_lane3;

    modport source (
        output valid, q0_lane0, q0_lane1, q0_lane2, q0_lane3,
        q1_lane0, q1_lane1, q1_lane2, q1_lane3,
        q2_lane0, q2_lane1, q2_lane2, q2_lane3,
        input  ready
    );
    modport sink (
        input  valid, q0_lane0, q0_lane1, q0_lane2, q0_lane3,
        q1_lane0, q1_lane1, q1_lane2, q1_lane3,
        q2_lane0, q2_lane1, q2_lane2, q2_lane3,
        output ready
    );
endinterface

// File: src/xoo_cell.sv
// Round cell: one Xoodoo round into a registered state stage with valid/ready.
`timescale 1ns / 1ps
module xoo_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  xoo_pkg::t_state i_state,
    input  xoo_pkg::t_lane  i_rc,
    output logic            o_valid,
    input  logic            i_ready,
    output xoo_pkg::t_state o_state
);
    import xoo_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_state r_state;
    logic   w_load;

    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_state <= xoo_round(i_state, i_rc);
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> r_valid)
        else $error("cell dropped a stalled transaction");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready |=> $stable(r_state))
        else $error("cell state changed while stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid |-> o_ready)
        else $error("empty cell refuses a transaction");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> r_valid)
        else $error("accepted transaction lost in cell");

endmodule

// File: src/xoodoo_permutation_12_round.sv
// Xoodoo-384 permutation: chain of round cells between the input and output channels.
// An accepted state passes through the NUM_ROUNDS cells in turn; each holds one state.
// Throughput: one state per cycle unless stalled; each cell applies one round.
// A stall at the output backs up through the cells; bubbles are filled as they move.
// Reset (synchronous, active low) clears only the cell valid bits; data is not reset.
`timescale 1ns / 1ps
module xoodoo_permutation_12_round (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xoo_in_if.sink    i_in,
    xoo_out_if.source o_out
);
    import xoo_pkg::*;

    logic   w_valid [NUM_ROUNDS+1];
    logic   w_ready [NUM_ROUNDS+1];
    t_state w_state [NUM_ROUNDS+1];

    assign w_valid[0]    = i_in.valid;
    assign i_in.ready    = w_ready[0];
    assign w_state[0][0] = {i_in.p0_lane3, i_in.p0_lane2, i_in.p0_lane1, i_in.p0_lane0};
    assign w_state[0][1] = {i_in.p1_lane3, i_in.p1_lane2, i_in.p1_lane1, i_in.p1_lane0};
    assign w_state[0][2] = {i_in.p2_lane3, i_in.p2_lane2, i_in.p2_lane1, i_in.p2_lane0};

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
        xoo_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_state (w_state[g]),
            .i_rc    (RC_TABLE[TOTAL_RC - NUM_ROUNDS + g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_state (w_state[g+1])
        );
    end

    assign o_out.valid          = w_valid[NUM_ROUNDS];
    assign w_ready[NUM_ROUNDS]  = o_out.ready;
    assign o_out.q0_lane0       = w_state[NUM_ROUNDS][0][0];
    assign o_out.q0_lane1       = w_state[NUM_ROUNDS][0][1];
    assign o_out.q0_lane2       = w_state[NUM_ROUNDS][0][2];
    assign o_out.q0_lane3       = w_state[NUM_ROUNDS][0][3];
    assign o_out.q1_lane0       = w_state[NUM_ROUNDS][1][0];
    assign o_out.q1_lane1       = w_state[NUM_ROUNDS][1][1];
    assign o_out.q1_lane2       = w_state[NUM_ROUNDS][1][2];
    assign o_out.q1_lane3       = w_state[NUM_ROUNDS][1][3];
    assign o_out.q2_lane0       = w_state[NUM_ROUNDS][2][0];
    assign o_out.q2_lane1       = w_state[NUM_ROUNDS][2][1];
    assign o_out.q2_lane2       = w_state[NUM_ROUNDS][2][2];
    assign o_out.q2_lane3       = w_state[NUM_ROUNDS][2][3];

endmodule
